// ===== hdl/qvr_pkg.sv =====
package qvr_pkg;

  // field widths
  localparam int QUAT_W = 16;
  localparam int VEC_W  = 32;

  // fraction bits of the quaternion and vector formats
  localparam int QUAT_FRAC = 14;
  localparam int VEC_FRAC  = 16;

  // datapath widths
  localparam int PROD1_W = QUAT_W + VEC_W;       // u * v
  localparam int CROSS_W = PROD1_W + 1;          // c = u x v
  localparam int PROD2_W = CROSS_W + QUAT_W;     // c * u or c * w
  localparam int SUM_W   = PROD2_W + 1;          // three products summed
  localparam int ACC_W   = SUM_W + 2;            // doubled sum plus vector term

  // rounding: sum has 2*QUAT_FRAC + VEC_FRAC fraction bits
  localparam int RND_SHIFT = 2 * QUAT_FRAC;
  localparam int RND_W     = ACC_W - RND_SHIFT;
  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W - RND_SHIFT){1'b0}}, 1'b1, {(RND_SHIFT - 1){1'b0}}};

  // saturation limits
  localparam logic [VEC_W-1:0] SAT_POS = {1'b0, {(VEC_W - 1){1'b1}}};
  localparam logic [VEC_W-1:0] SAT_NEG = {1'b1, {(VEC_W - 1){1'b0}}};

  // quaternion reset value: 1.0 in Q2.14
  localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1 << QUAT_FRAC);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUAT_I      = 2'd0,
    CFG_QUAT_J      = 2'd1,
    CFG_QUAT_K      = 2'd2,
    CFG_QUAT_SCALAR = 2'd3
  } cfg_reg_t;

endpackage

// ===== hdl/qvr_lane.sv =====
module qvr_lane
  import qvr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic signed [CROSS_W-1:0] c_own,
  input  logic signed [CROSS_W-1:0] c_a,
  input  logic signed [CROSS_W-1:0] c_b,
  input  logic signed [QUAT_W-1:0]  w,
  input  logic signed [QUAT_W-1:0]  u_a,
  input  logic signed [QUAT_W-1:0]  u_b,
  input  logic signed [VEC_W-1:0]   v,
  output logic                      out_valid,
  output logic        [VEC_W-1:0]   rot,
  output logic                      sat
);

  // stage a: the three products of one output component
  logic                      m_valid_r;
  logic signed [PROD2_W-1:0] m0_r, m1_r, m2_r;
  logic signed [PROD2_W-1:0] m0_nxt, m1_nxt, m2_nxt;
  logic signed [VEC_W-1:0]   mv_r;

  // stage b: their sum
  logic                      s_valid_r;
  logic signed [SUM_W-1:0]   s_r;
  logic signed [SUM_W-1:0]   s_nxt;
  logic signed [VEC_W-1:0]   sv_r;

  // stage c: round, saturate, output register
  logic                      o_valid_r;
  logic        [VEC_W-1:0]   rot_r;
  logic        [VEC_W-1:0]   rot_nxt;
  logic                      sat_r;
  logic                      sat_nxt;
  logic signed [ACC_W-1:0]   acc;
  logic        [RND_W-1:0]   rnd;
  logic                      fits;

  // products w*c_own, u_a*c_b, u_b*c_a
  always_comb begin
    m0_nxt = PROD2_W'(c_own) * PROD2_W'(w);
    m1_nxt = PROD2_W'(c_b) * PROD2_W'(u_a);
    m2_nxt = PROD2_W'(c_a) * PROD2_W'(u_b);
  end

  // cross terms summed
  always_comb begin
    s_nxt = SUM_W'(m0_r) + SUM_W'(m1_r) - SUM_W'(m2_r);
  end

  // doubled sum plus vector, round half up, clip to 32 bits
  always_comb begin
    acc  = (ACC_W'(s_r) <<< 1) + (ACC_W'(sv_r) <<< RND_SHIFT) + RND_HALF;
    rnd  = acc[ACC_W-1:RND_SHIFT];
    fits = (&rnd[RND_W-1:VEC_W-1]) | ~(|rnd[RND_W-1:VEC_W-1]);
    if (fits) begin
      rot_nxt = rnd[VEC_W-1:0];
      sat_nxt = 1'b0;
    end else begin
      rot_nxt = rnd[RND_W-1] ? SAT_NEG : SAT_POS;
      sat_nxt = 1'b1;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      m_valid_r <= in_valid;
      s_valid_r <= m_valid_r;
      o_valid_r <= s_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    m0_r  <= m0_nxt;
    m1_r  <= m1_nxt;
    m2_r  <= m2_nxt;
    mv_r  <= v;
    s_r   <= s_nxt;
    sv_r  <= mv_r;
    rot_r <= rot_nxt;
    sat_r <= sat_nxt;
  end

  assign out_valid = o_valid_r;
  assign rot       = rot_r;
  assign sat       = sat_r;

endmodule

// ===== hdl/quaternion_vector_rotate.sv =====
// Rotates one Q16.16 vector per clock by the quaternion held in the four
// configuration registers (vector part quat_i/j/k and scalar part, Q2.14,
// identity after reset), computing v + 2w(u x v) + 2u x (u x v) exactly and
// rounding once to nearest. busy is never raised, so a request can be issued
// on every cycle; each request gives one result, marked by out_valid for
// one cycle, in request order. The pipeline has five register stages: u*v
// products, cross product, second products, their sum, and round/saturate.
// There is no back-pressure: the result must be taken in the cycle it
// appears. out_saturated flags a component clipped to range.
// The quaternion is not normalized; write it only while no request is in
// flight.
module quaternion_vector_rotate
  import qvr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VEC_W-1:0]       in_vec_x,
  input  logic [VEC_W-1:0]       in_vec_y,
  input  logic [VEC_W-1:0]       in_vec_z,
  output logic                   out_valid,
  output logic [VEC_W-1:0]       out_rot_x,
  output logic [VEC_W-1:0]       out_rot_y,
  output logic [VEC_W-1:0]       out_rot_z,
  output logic                   out_saturated,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [QUAT_W-1:0]      cfg_wdata
);

  // quaternion registers
  logic signed [QUAT_W-1:0] quat_i_r, quat_j_r, quat_k_r, quat_w_r;
  logic signed [QUAT_W-1:0] quat_i_nxt, quat_j_nxt, quat_k_nxt, quat_w_nxt;

  // stage 1: u*v products
  logic                      v1_valid_r;
  logic signed [PROD1_W-1:0] p_jz_r, p_ky_r, p_kx_r, p_iz_r, p_iy_r, p_jx_r;
  logic signed [VEC_W-1:0]   v1_x_r, v1_y_r, v1_z_r;
  logic signed [VEC_W-1:0]   vin_x, vin_y, vin_z;

  // stage 2: cross product u x v
  logic                      v2_valid_r;
  logic signed [CROSS_W-1:0] c_x_r, c_y_r, c_z_r;
  logic signed [CROSS_W-1:0] c_x_nxt, c_y_nxt, c_z_nxt;
  logic signed [VEC_W-1:0]   v2_x_r, v2_y_r, v2_z_r;

  // lane results
  logic                      lane_valid_x, lane_valid_y, lane_valid_z;
  logic                      sat_x, sat_y, sat_z;

  assign busy  = 1'b0;
  assign vin_x = in_vec_x;
  assign vin_y = in_vec_y;
  assign vin_z = in_vec_z;

  // configuration writes
  always_comb begin
    quat_i_nxt = quat_i_r;
    quat_j_nxt = quat_j_r;
    quat_k_nxt = quat_k_r;
    quat_w_nxt = quat_w_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        CFG_QUAT_I:      quat_i_nxt = cfg_wdata;
        CFG_QUAT_J:      quat_j_nxt = cfg_wdata;
        CFG_QUAT_K:      quat_k_nxt = cfg_wdata;
        CFG_QUAT_SCALAR: quat_w_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_i_r <= '0;
      quat_j_r <= '0;
      quat_k_r <= '0;
      quat_w_r <= QUAT_ONE;
    end else begin
      quat_i_r <= quat_i_nxt;
      quat_j_r <= quat_j_nxt;
      quat_k_r <= quat_k_nxt;
      quat_w_r <= quat_w_nxt;
    end
  end

  // cross product differences
  always_comb begin
    c_x_nxt = CROSS_W'(p_jz_r) - CROSS_W'(p_ky_r);
    c_y_nxt = CROSS_W'(p_kx_r) - CROSS_W'(p_iz_r);
    c_z_nxt = CROSS_W'(p_iy_r) - CROSS_W'(p_jx_r);
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_valid_r <= 1'b0;
      v2_valid_r <= 1'b0;
    end else begin
      v1_valid_r <= start & ~busy;
      v2_valid_r <= v1_valid_r;
    end
  end

  // front stage payload
  always_ff @(posedge clk) begin
    p_jz_r <= PROD1_W'(quat_j_r) * PROD1_W'(vin_z);
    p_ky_r <= PROD1_W'(quat_k_r) * PROD1_W'(vin_y);
    p_kx_r <= PROD1_W'(quat_k_r) * PROD1_W'(vin_x);
    p_iz_r <= PROD1_W'(quat_i_r) * PROD1_W'(vin_z);
    p_iy_r <= PROD1_W'(quat_i_r) * PROD1_W'(vin_y);
    p_jx_r <= PROD1_W'(quat_j_r) * PROD1_W'(vin_x);
    v1_x_r <= vin_x;
    v1_y_r <= vin_y;
    v1_z_r <= vin_z;
    c_x_r  <= c_x_nxt;
    c_y_r  <= c_y_nxt;
    c_z_r  <= c_z_nxt;
    v2_x_r <= v1_x_r;
    v2_y_r <= v1_y_r;
    v2_z_r <= v1_z_r;
  end

  // x lane: 2w*c_x + 2(u_y*c_z - u_z*c_y)
  qvr_lane u_lane_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_valid_r),
    .c_own     (c_x_r),
    .c_a       (c_y_r),
    .c_b       (c_z_r),
    .w         (quat_w_r),
    .u_a       (quat_j_r),
    .u_b       (quat_k_r),
    .v         (v2_x_r),
    .out_valid (lane_valid_x),
    .rot       (out_rot_x),
    .sat       (sat_x)
  );

  // y lane: 2w*c_y + 2(u_z*c_x - u_x*c_z)
  qvr_lane u_lane_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_valid_r),
    .c_own     (c_y_r),
    .c_a       (c_z_r),
    .c_b       (c_x_r),
    .w         (quat_w_r),
    .u_a       (quat_k_r),
    .u_b       (quat_i_r),
    .v         (v2_y_r),
    .out_valid (lane_valid_y),
    .rot       (out_rot_y),
    .sat       (sat_y)
  );

  // z lane: 2w*c_z + 2(u_x*c_y - u_y*c_x)
  qvr_lane u_lane_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_valid_r),
    .c_own     (c_z_r),
    .c_a       (c_x_r),
    .c_b       (c_y_r),
    .w         (quat_w_r),
    .u_a       (quat_i_r),
    .u_b       (quat_j_r),
    .v         (v2_z_r),
    .out_valid (lane_valid_z),
    .rot       (out_rot_z),
    .sat       (sat_z)
  );

  // result strobe and combined clip flag
  assign out_valid     = lane_valid_x;
  assign out_saturated = sat_x | sat_y | sat_z;

`ifndef NO_ASSERTIONS
  // every request gives exactly one result, and no result comes without a request
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) &&
     $past(rst_n, 4) && $past(rst_n, 5)) |-> (out_valid == $past(start, 5)))
    else $error("result strobe does not match request five cycles earlier");

  // the three lanes stay in step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_valid_x == lane_valid_y) && (lane_valid_x == lane_valid_z))
    else $error("lane valid bits out of step");

  // a clipped result carries a limit value in some component
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_rot_x == SAT_POS || out_rot_x == SAT_NEG ||
       out_rot_y == SAT_POS || out_rot_y == SAT_NEG ||
       out_rot_z == SAT_POS || out_rot_z == SAT_NEG))
    else $error("saturated flag without a limit value");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");
`endif

endmodule

// ===== tb/tb_quaternion_vector_rotate.sv =====
`timescale 1ns / 100ps

module tb_quaternion_vector_rotate;
  import qvr_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [VEC_W-1:0] x;
    logic [VEC_W-1:0] y;
    logic [VEC_W-1:0] z;
    logic             sat;
  } rot_t;

  typedef struct packed {
    logic [QUAT_W-1:0] qi;
    logic [QUAT_W-1:0] qj;
    logic [QUAT_W-1:0] qk;
    logic [QUAT_W-1:0] qs;
  } quat_t;

  typedef struct packed {
    logic [2:0]       qsel;
    logic [VEC_W-1:0] vx;
    logic [VEC_W-1:0] vy;
    logic [VEC_W-1:0] vz;
    logic             typed;
    rot_t             rot;
  } dir_row_t;

  // quaternion settings used by the directed rows
  localparam logic [2:0] Q_IDENTITY  = 3'd0;
  localparam logic [2:0] Q_HALF_Z    = 3'd1;
  localparam logic [2:0] Q_ALL_MAX   = 3'd2;
  localparam logic [2:0] Q_ALL_MIN   = 3'd3;
  localparam logic [2:0] Q_QUARTER_X = 3'd4;
  localparam logic [2:0] Q_TINY_I    = 3'd5;

  localparam quat_t QUAT_SETS [6] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h4000},
    '{16'h0000, 16'h0000, 16'h4000, 16'h0000},
    '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
    '{16'h8000, 16'h8000, 16'h8000, 16'h8000},
    '{16'h2D41, 16'h0000, 16'h0000, 16'h2D41},
    '{16'h0001, 16'h0000, 16'h0000, 16'h0000}
  };

  localparam rot_t NO_ROT = '0;
  localparam int N_DIR = 20;

  // directed requests; typed rows carry a result that is obvious by inspection
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{Q_IDENTITY, 32'h00000000, 32'h00000000, 32'h00000000, 1'b1,
      '{32'h00000000, 32'h00000000, 32'h00000000, 1'b0}},
    '{Q_IDENTITY, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 1'b1,
      '{32'h7FFFFFFF, 32'h80000000, 32'h00000001, 1'b0}},
    '{Q_IDENTITY, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1,
      '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0}},
    '{Q_IDENTITY, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 1'b1,
      '{32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 1'b0}},
    // half turn about z negates x and y, clipping the most negative value
    '{Q_HALF_Z, 32'h00010000, 32'hFFFF0000, 32'h7FFFFFFF, 1'b1,
      '{32'hFFFF0000, 32'h00010000, 32'h7FFFFFFF, 1'b0}},
    '{Q_HALF_Z, 32'h80000000, 32'h00000005, 32'h80000000, 1'b1,
      '{32'h7FFFFFFF, 32'hFFFFFFFB, 32'h80000000, 1'b1}},
    '{Q_HALF_Z, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 1'b1,
      '{32'h80000001, 32'h7FFFFFFF, 32'h00000000, 1'b1}},
    // non-unit quaternions at both register extremes, then a quarter turn about x
    '{Q_ALL_MAX, 32'h00000000, 32'h00000000, 32'h00000000, 1'b0, NO_ROT},
    '{Q_ALL_MAX, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, NO_ROT},
    '{Q_ALL_MAX, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, NO_ROT},
    '{Q_ALL_MAX, 32'h00000001, 32'hFFFFFFFF, 32'h00000000, 1'b0, NO_ROT},
    '{Q_ALL_MIN, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0, NO_ROT},
    '{Q_ALL_MIN, 32'h00010000, 32'h00000000, 32'h00000000, 1'b0, NO_ROT},
    '{Q_ALL_MIN, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, NO_ROT},
    '{Q_QUARTER_X, 32'h00010000, 32'h00020000, 32'h00030000, 1'b0, NO_ROT},
    '{Q_QUARTER_X, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, NO_ROT},
    '{Q_QUARTER_X, 32'hFFF00000, 32'h00100000, 32'hFFFFFFFF, 1'b0, NO_ROT},
    // tiny i part leaves exact half-lsb remainders on y and z: rounding ties
    '{Q_TINY_I, 32'h00000000, 32'h04000000, 32'h04000000, 1'b0, NO_ROT},
    '{Q_TINY_I, 32'h00000000, 32'hFC000000, 32'hFC000000, 1'b0, NO_ROT},
    '{Q_TINY_I, 32'h00000001, 32'h0C000000, 32'hF4000000, 1'b0, NO_ROT}
  };

  localparam logic [QUAT_W-1:0] QUAT_EXTREMES [5] = '{
    16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000
  };
  localparam logic [VEC_W-1:0] VEC_EXTREMES [5] = '{
    32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h00000001, 32'hFFFFFFFF
  };

  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int IDLE_LIMIT      = 1000;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [VEC_W-1:0]   in_vec_x = '0;
  logic [VEC_W-1:0]   in_vec_y = '0;
  logic [VEC_W-1:0]   in_vec_z = '0;
  logic               out_valid;
  logic [VEC_W-1:0]   out_rot_x;
  logic [VEC_W-1:0]   out_rot_y;
  logic [VEC_W-1:0]   out_rot_z;
  logic               out_saturated;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [QUAT_W-1:0]  cfg_wdata = '0;

  // tb-side tag that travels with each request
  logic               use_typed = 1'b0;
  rot_t               typed_rot = '0;

  quat_t              held_quat;
  rot_t               rot_queue [$];
  int                 vectors_sent = 0;
  int                 results_seen = 0;
  int                 sat_results = 0;
  int                 quat_loads = 0;
  int                 failures = 0;
  int                 idle_cycles = 0;

  quaternion_vector_rotate u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_vec_x     (in_vec_x),
    .in_vec_y     (in_vec_y),
    .in_vec_z     (in_vec_z),
    .out_valid    (out_valid),
    .out_rot_x    (out_rot_x),
    .out_rot_y    (out_rot_y),
    .out_rot_z    (out_rot_z),
    .out_saturated(out_saturated),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // r = v + 2w(u x v) + 2u x (u x v), rounded half up and clipped to 32 bits
  function automatic rot_t rotate_vector(logic [VEC_W-1:0] vx, logic [VEC_W-1:0] vy,
                                         logic [VEC_W-1:0] vz);
    longint vec [3];
    longint axis [3];
    longint uxv [3];
    longint scal;
    wide_t  sum;
    wide_t  scaled;
    int     a;
    int     b;
    int     n;
    logic [VEC_W-1:0] comp [3];
    rot_t   res;
    vec[0]  = longint'($signed(vx));
    vec[1]  = longint'($signed(vy));
    vec[2]  = longint'($signed(vz));
    axis[0] = longint'($signed(held_quat.qi));
    axis[1] = longint'($signed(held_quat.qj));
    axis[2] = longint'($signed(held_quat.qk));
    scal    = longint'($signed(held_quat.qs));
    uxv[0]  = axis[1] * vec[2] - axis[2] * vec[1];
    uxv[1]  = axis[2] * vec[0] - axis[0] * vec[2];
    uxv[2]  = axis[0] * vec[1] - axis[1] * vec[0];
    res.sat = 1'b0;
    for (n = 0; n < 3; n++) begin
      a = (n + 1) % 3;
      b = (n + 2) % 3;
      sum = (wide_t'(vec[n]) <<< RND_SHIFT)
          + wide_t'(uxv[n]) * wide_t'(2 * scal)
          + wide_t'(uxv[b]) * wide_t'(2 * axis[a])
          - wide_t'(uxv[a]) * wide_t'(2 * axis[b]);
      scaled = (sum + (wide_t'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
      if (scaled[127:VEC_W-1] == '0 || scaled[127:VEC_W-1] == '1) begin
        comp[n] = scaled[VEC_W-1:0];
      end else begin
        comp[n] = scaled[127] ? SAT_NEG : SAT_POS;
        res.sat = 1'b1;
      end
    end
    res.x = comp[0];
    res.y = comp[1];
    res.z = comp[2];
    return res;
  endfunction

  // scoreboard: predict on each accepted request, compare each result
  always @(posedge clk) begin : scoreboard
    rot_t want;
    if (!rst_n) begin
      held_quat = '{16'h0000, 16'h0000, 16'h0000, QUAT_ONE};
      rot_queue.delete();
    end else begin
      if (start && !busy) begin
        if (use_typed) rot_queue.push_back(typed_rot);
        else rot_queue.push_back(rotate_vector(in_vec_x, in_vec_y, in_vec_z));
      end
      if (out_valid) begin
        results_seen++;
        if (out_saturated) sat_results++;
        if (rot_queue.size() == 0) begin
          $error("result with no request outstanding: %h %h %h sat %b",
                 out_rot_x, out_rot_y, out_rot_z, out_saturated);
          failures++;
        end else begin
          want = rot_queue.pop_front();
          if (out_rot_x !== want.x) begin
            $error("rot_x: expected %h, got %h", want.x, out_rot_x);
            failures++;
          end
          if (out_rot_y !== want.y) begin
            $error("rot_y: expected %h, got %h", want.y, out_rot_y);
            failures++;
          end
          if (out_rot_z !== want.z) begin
            $error("rot_z: expected %h, got %h", want.z, out_rot_z);
            failures++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated: expected %b, got %b", want.sat, out_saturated);
            failures++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_QUAT_I:      held_quat.qi = cfg_wdata;
          CFG_QUAT_J:      held_quat.qj = cfg_wdata;
          CFG_QUAT_K:      held_quat.qk = cfg_wdata;
          CFG_QUAT_SCALAR: held_quat.qs = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // watchdog on cycles without any traffic
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // issue one request after an optional idle gap and wait for it to be taken
  task automatic send_vector(logic [VEC_W-1:0] vx, logic [VEC_W-1:0] vy,
                             logic [VEC_W-1:0] vz, logic typed, rot_t rot, int gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_vec_x  <= vx;
    in_vec_y  <= vy;
    in_vec_z  <= vz;
    use_typed <= typed;
    typed_rot <= rot;
    do @(posedge clk); while (busy);
    vectors_sent++;
  endtask

  // stop issuing and let every outstanding result come back
  task automatic drain_pipe();
    start <= 1'b0;
    while (results_seen < vectors_sent) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_quat(quat_t q);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_QUAT_I;
    cfg_wdata <= q.qi;
    @(posedge clk);
    cfg_idx   <= CFG_QUAT_J;
    cfg_wdata <= q.qj;
    @(posedge clk);
    cfg_idx   <= CFG_QUAT_K;
    cfg_wdata <= q.qk;
    @(posedge clk);
    cfg_idx   <= CFG_QUAT_SCALAR;
    cfg_wdata <= q.qs;
    @(posedge clk);
    cfg_we    <= 1'b0;
    quat_loads++;
  endtask

  // kinds 0-2 near-unit, 3 raw random, 4 extremes per register
  function automatic quat_t draw_quat(int kind);
    real   comp [4];
    real   nrm;
    int    t;
    int    k;
    quat_t q;
    if (kind == 3) begin
      q = {$urandom, $urandom};
    end else if (kind == 4) begin
      q.qi = QUAT_EXTREMES[$urandom_range(0, 4)];
      q.qj = QUAT_EXTREMES[$urandom_range(0, 4)];
      q.qk = QUAT_EXTREMES[$urandom_range(0, 4)];
      q.qs = QUAT_EXTREMES[$urandom_range(0, 4)];
    end else begin
      nrm = 0.0;
      for (k = 0; k < 4; k++) begin
        t = $urandom_range(0, 60000);
        comp[k] = $itor(t - 30000);
        nrm = nrm + comp[k] * comp[k];
      end
      nrm = $sqrt(nrm);
      if (nrm < 1.0) begin
        q = QUAT_SETS[Q_IDENTITY];
      end else begin
        q.qi = QUAT_W'($rtoi(comp[0] * 16384.0 / nrm));
        q.qj = QUAT_W'($rtoi(comp[1] * 16384.0 / nrm));
        q.qk = QUAT_W'($rtoi(comp[2] * 16384.0 / nrm));
        q.qs = QUAT_W'($rtoi(comp[3] * 16384.0 / nrm));
      end
    end
    return q;
  endfunction

  // kind 0-5 full range, 6-8 small magnitude, 9 extremes
  function automatic logic [VEC_W-1:0] draw_component(int kind);
    if (kind <= 5) return $urandom;
    if (kind <= 8) return $urandom_range(0, 2**21) - 2**20;
    return VEC_EXTREMES[$urandom_range(0, 4)];
  endfunction

  // mode 0 back to back, 1 uniform gaps, 2 rare gaps
  function automatic int draw_gap(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 14);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
  endfunction

  initial begin
    logic [2:0] cur_sel;
    int r;
    int p;
    int k;
    int kind;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, starting from the reset quaternion
    cur_sel = Q_IDENTITY;
    for (r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].qsel != cur_sel) begin
        drain_pipe();
        cur_sel = DIR_ROWS[r].qsel;
        load_quat(QUAT_SETS[cur_sel]);
      end
      send_vector(DIR_ROWS[r].vx, DIR_ROWS[r].vy, DIR_ROWS[r].vz,
                  DIR_ROWS[r].typed, DIR_ROWS[r].rot, draw_gap(1));
    end

    // random phases, one quaternion each
    for (p = 0; p < RAND_PHASES; p++) begin
      drain_pipe();
      load_quat(draw_quat(p % 5));
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        kind = $urandom_range(0, 9);
        send_vector(draw_component(kind), draw_component(kind), draw_component(kind),
                    1'b0, NO_ROT, draw_gap(p % 3));
      end
    end

    drain_pipe();
    repeat (10) @(posedge clk);
    if (rot_queue.size() != 0) begin
      $error("%0d expected results never arrived", rot_queue.size());
      failures++;
    end
    $display("rotated %0d vectors under %0d quaternion loads plus the reset value",
             vectors_sent, quat_loads);
    $display("%0d results checked, %0d of them clipped", results_seen, sat_results);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== quaternion_vector_rotate.f =====
hdl/qvr_pkg.sv
hdl/qvr_lane.sv
hdl/quaternion_vector_rotate.sv
tb/tb_quaternion_vector_rotate.sv
